[src/bf5x5_pkg.sv]
// Shared types and constants for the 5x5 box filter.
`default_nettype none

package bf5x5_pkg;

   localparam int PIX_W     = 16;           // one pixel
   localparam int ROWS      = 4;            // lines held in the line store
   localparam int LINE_W    = ROWS * PIX_W; // one line store column
   localparam int WIN       = 5;            // window edge
   localparam int EDGE      = 4;            // first column/line with a full window
   localparam int MIN_DIM   = 5;

   localparam int LEN_W     = 11;           // line_length register
   localparam int CNT_W     = 13;           // line_count register
   localparam int CSR_W     = 13;           // widest register
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_COUNT  = 1'b1;

   // Sum of one column of five pixels and of the whole window.
   localparam int COL_SUM_W = 19;
   localparam int WIN_SUM_W = 21;

   // Division by 25 as a multiply by a rounded-up reciprocal. The error term
   // (11) stays below 2^(26-21), so the quotient is exact for all sums.
   localparam int              RECIP_SHIFT = 26;
   localparam int              RECIP_W     = 22;
   localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;
   localparam int              PROD_W      = WIN_SUM_W + RECIP_W;

   typedef logic [PIX_W-1:0]     pixel_type;
   typedef logic [COL_SUM_W-1:0] col_sum_type;

endpackage

`default_nettype wire

[src/box_filter_5x5_stream_top.sv]
// 5x5 box filter over a raster pixel stream, top level.
`default_nettype none

// Pixels enter in raster order, one beat per clock, and for every pixel whose
// full 5x5 neighborhood lies inside the frame the block returns the truncated
// mean of those 25 pixels when the neighborhood's bottom-right pixel arrives;
// border pixels give no result, and tlast marks the last result of a frame.
// The block takes one pixel per clock for as long as the result side takes
// its beats; each result is held in an output register, and the whole
// pipeline halts while a result waits. The rate is set by the line store,
// which is read and written once per pixel through one read and one write
// port. The line store is not cleared after reset: its contents only reach
// a result once four lines of the frame have been written. Writing either
// geometry register starts a new frame with the next pixel; values below 5
// act as 5 and values above the maximum act as the maximum.
module box_filter_5x5_stream_top
   import bf5x5_pkg::*;
#(
   parameter int MAX_LINE  = 1024,
   parameter int MAX_LINES = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // pixel stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [PIX_W-1:0]     req_tdata,   // [15:0] pixel
   // filtered stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [PIX_W-1:0]     rsp_tdata,   // [15:0] mean_value
   output logic                      rsp_tlast,   // frame_last
   // register writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int X_W  = $clog2(MAX_LINE);
   localparam int Y_W  = $clog2(MAX_LINES);
   localparam int XC_W = ((X_W > LEN_W) ? X_W : LEN_W) + 1;
   localparam int YC_W = ((Y_W > CNT_W) ? Y_W : CNT_W) + 1;
   localparam int LEN_RESET = (MAX_LINE < 1024) ? MAX_LINE : 1024;
   localparam int CNT_RESET = (MAX_LINES < 1024) ? MAX_LINES : 1024;

   // Geometry registers and raster position.
   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic [CNT_W-1:0] line_count_ff, line_count_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [Y_W-1:0]   y_ff, y_in;

   // Pipeline.
   logic              pipe_en;
   logic              accept;
   logic              emit;
   logic              last;
   logic              p1_valid_ff, p1_emit_ff, p1_last_ff;
   pixel_type         p1_pixel_ff;
   logic [X_W-1:0]    p1_slot_ff;
   logic [LINE_W-1:0] line_rd;
   logic [LINE_W-1:0] line_wr;
   logic              line_we;
   col_sum_type       col_new;
   col_sum_type       col_sum_ff [WIN];
   logic              p2_valid_ff, p2_last_ff;
   logic [WIN_SUM_W-1:0] win_sum;
   logic [WIN_SUM_W-1:0] sum_ff;
   logic              p3_valid_ff, p3_last_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              p4_valid_ff, p4_last_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   pixel_type         rsp_data_ff;

   // The whole pipeline moves as one; it halts only when a result waits.
   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign accept     = req_tvalid && pipe_en;

   // Register writes with clamping.
   always_comb begin
      line_length_in = line_length_ff;
      line_count_in  = line_count_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_LINE_LENGTH: begin
               if (csr_wdata[LEN_W-1:0] < LEN_W'(MIN_DIM)) begin
                  line_length_in = LEN_W'(MIN_DIM);
               end else if (32'(csr_wdata[LEN_W-1:0]) > MAX_LINE) begin
                  line_length_in = LEN_W'(MAX_LINE);
               end else begin
                  line_length_in = csr_wdata[LEN_W-1:0];
               end
            end
            CSR_LINE_COUNT: begin
               if (csr_wdata[CNT_W-1:0] < CNT_W'(MIN_DIM)) begin
                  line_count_in = CNT_W'(MIN_DIM);
               end else if (32'(csr_wdata[CNT_W-1:0]) > MAX_LINES) begin
                  line_count_in = CNT_W'(MAX_LINES);
               end else begin
                  line_count_in = csr_wdata[CNT_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Raster position of the pixel on the input.
   always_comb begin
      emit = (XC_W'(x_ff) >= XC_W'(EDGE)) && (YC_W'(y_ff) >= YC_W'(EDGE));
      last = (XC_W'(x_ff) + XC_W'(1) == XC_W'(line_length_ff)) &&
             (YC_W'(y_ff) + YC_W'(1) == YC_W'(line_count_ff));
      x_in = x_ff;
      y_in = y_ff;
      if (csr_we) begin
         x_in = '0;
         y_in = '0;
      end else if (accept) begin
         if (XC_W'(x_ff) + XC_W'(1) >= XC_W'(line_length_ff)) begin
            x_in = '0;
            if (YC_W'(y_ff) + YC_W'(1) >= YC_W'(line_count_ff)) begin
               y_in = '0;
            end else begin
               y_in = y_ff + Y_W'(1);
            end
         end else begin
            x_in = x_ff + X_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LEN_W'(LEN_RESET);
         line_count_ff  <= CNT_W'(CNT_RESET);
         x_ff           <= '0;
         y_ff           <= '0;
      end else begin
         line_length_ff <= line_length_in;
         line_count_ff  <= line_count_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
      end
   end

   // Line store: each column holds the four lines above, newest in the low bits.
   bf5x5_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_LINE)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (p1_slot_ff),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (x_ff),
      .rd_data (line_rd)
   );

   assign line_we = pipe_en && p1_valid_ff;
   assign line_wr = {line_rd[LINE_W-PIX_W-1:0], p1_pixel_ff};

   // Sum of the column entering the window.
   always_comb begin
      col_new = col_sum_type'(p1_pixel_ff);
      for (int r = 0; r < ROWS; r++) begin
         col_new = col_new + col_sum_type'(line_rd[r*PIX_W +: PIX_W]);
      end
   end

   always_comb begin
      win_sum = '0;
      for (int c = 0; c < WIN; c++) begin
         win_sum = win_sum + WIN_SUM_W'(col_sum_ff[c]);
      end
   end

   // Column sums stand in for the 5x5 window; they shift once per pixel.
   always_ff @(posedge clock) begin
      if (pipe_en && p1_valid_ff) begin
         for (int c = 0; c < WIN - 1; c++) begin
            col_sum_ff[c] <= col_sum_ff[c+1];
         end
         col_sum_ff[WIN-1] <= col_new;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_pixel_ff <= req_tdata;
         p1_slot_ff  <= x_ff;
         p1_emit_ff  <= emit;
         p1_last_ff  <= last;
         p2_last_ff  <= p1_last_ff;
         sum_ff      <= win_sum;
         p3_last_ff  <= p2_last_ff;
         prod_ff     <= PROD_W'(sum_ff) * PROD_W'(RECIP_25);
         p4_last_ff  <= p3_last_ff;
         rsp_data_ff <= prod_ff[RECIP_SHIFT +: PIX_W];
         rsp_last_ff <= p4_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         p1_valid_ff  <= accept;
         p2_valid_ff  <= p1_valid_ff && p1_emit_ff;
         p3_valid_ff  <= p2_valid_ff;
         p4_valid_ff  <= p3_valid_ff;
         rsp_valid_ff <= p4_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[src/bf5x5_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bf5x5_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/bf5x5_checker.sv]
// Port-level checks for the 5x5 box filter and their binding to the top level.
`default_nettype none

module bf5x5_checker
   import bf5x5_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [PIX_W-1:0]     rsp_tdata,
   input wire logic                 rsp_tlast
);

   // A result beat that is not taken holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A waiting result halts the input side.
   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while a result waits");

   // With no result pending the block always takes a pixel.
   a_free_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input refused with empty output");

   // A pixel offered while a result waits is not taken.
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("pixel beat accepted during an output stall");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat shown right after reset");

endmodule

bind box_filter_5x5_stream_top bf5x5_checker u_bf5x5_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[tb/box_filter_5x5_stream_top_test.sv]
// Self-checking testbench for the 5x5 box filter stream top level.
`timescale 1ns / 1ps

module box_filter_5x5_stream_top_test;
   import bf5x5_pkg::*;

   localparam int TB_MAX_LINE  = 1024;
   localparam int TB_MAX_LINES = 4096;
   localparam int WIN_AREA     = WIN * WIN;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_MAX   = 20;

   typedef struct packed {
      pixel_type mean;
      logic      last;
   } filt_beat_type;

   typedef struct {
      bit                   reg_write;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [CSR_W-1:0]     reg_val;
      int                   beats;
      pixel_type            fill;
      pixel_type            tail;
      bit                   typed;
      pixel_type            want_mean;
      bit                   want_last;
   } plan_row_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [PIX_W-1:0]     req_tdata  = '0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr   = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;
   wire logic            req_tready;
   wire logic            rsp_tvalid;
   wire logic [PIX_W-1:0] rsp_tdata;
   wire logic            rsp_tlast;

   // Side information that travels with each pixel beat: a hand-written result.
   logic      beat_typed = 1'b0;
   pixel_type beat_mean  = '0;
   logic      beat_last  = 1'b0;

   // Idle rates of both sides, in percent of cycles.
   int send_idle_pct = 25;
   int recv_idle_pct = 80;

   // Long receiver hold-off, requested by toggling hold_req.
   logic hold_req  = 1'b0;
   logic hold_ack  = 1'b0;
   int   hold_left = 0;

   // Filter model state.
   logic [LINE_W-1:0] line_mem [TB_MAX_LINE];
   pixel_type         win_px [WIN][WIN];
   int unsigned       col_pos, row_pos, geom_len, geom_cnt;

   filt_beat_type pending_means [$];
   int         mismatches = 0;
   int         means_checked = 0;
   int         frames_closed = 0;
   int         sent_count = 0;
   int         reg_writes = 0;
   int unsigned eff_len = 1024, eff_cnt = 1024;

   plan_row_type plan [4];

   box_filter_5x5_stream_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] pixel
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] mean_value
      .rsp_tlast  (rsp_tlast),   // frame_last
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < MIN_DIM)
         return MIN_DIM;
      if (v > hi)
         return hi;
      return v;
   endfunction

   task automatic apply_geometry(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      if (idx == CSR_LINE_LENGTH)
         geom_len = clamp_dim(32'(val[LEN_W-1:0]), TB_MAX_LINE);
      else
         geom_cnt = clamp_dim(32'(val[CNT_W-1:0]), TB_MAX_LINES);
      col_pos = 0;
      row_pos = 0;
   endtask

   // One pixel through the window; gives the mean when the window is interior.
   task automatic box_mean_step(input pixel_type px, output bit has_mean,
                                output pixel_type mean, output bit last);
      logic [LINE_W-1:0] column;
      int unsigned       slot, total;
      int                r, c;
      begin
         slot   = col_pos % TB_MAX_LINE;
         column = line_mem[slot];
         for (r = 0; r < WIN; r++)
            for (c = 0; c < WIN - 1; c++)
               win_px[r][c] = win_px[r][c+1];
         win_px[0][WIN-1] = column[63:48];
         win_px[1][WIN-1] = column[47:32];
         win_px[2][WIN-1] = column[31:16];
         win_px[3][WIN-1] = column[15:0];
         win_px[4][WIN-1] = px;
         line_mem[slot] = {column[LINE_W-PIX_W-1:0], px};
         has_mean = 1'b0;
         mean     = '0;
         last     = 1'b0;
         if (col_pos >= EDGE && row_pos >= EDGE) begin
            total = 0;
            for (r = 0; r < WIN; r++)
               for (c = 0; c < WIN; c++)
                  total += 32'(win_px[r][c]);
            mean     = pixel_type'(total / WIN_AREA);
            last     = (col_pos + 1 == geom_len) && (row_pos + 1 == geom_cnt);
            has_mean = 1'b1;
         end
         col_pos++;
         if (col_pos >= geom_len) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= geom_cnt)
               row_pos = 0;
         end
      end
   endtask

   // Watches all three ports: register writes and pixel beats feed the model,
   // result beats are compared with the oldest predicted mean.
   bit            pred_has;
   pixel_type     pred_mean;
   bit            pred_last;
   filt_beat_type oldest;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TB_MAX_LINE; i++)
            line_mem[i] = '0;
         for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++)
               win_px[r][c] = '0;
         col_pos  = 0;
         row_pos  = 0;
         geom_len = 1024;
         geom_cnt = 1024;
      end else begin
         if (csr_we)
            apply_geometry(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) begin
            box_mean_step(req_tdata, pred_has, pred_mean, pred_last);
            if (beat_typed)
               pending_means.push_back('{beat_mean, beat_last});
            else if (pred_has)
               pending_means.push_back('{pred_mean, pred_last});
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_means.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: unexpected result beat, expected none, got mean %0d last %0b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               oldest = pending_means.pop_front();
               means_checked++;
               if (rsp_tlast)
                  frames_closed++;
               if (rsp_tdata !== oldest.mean) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("%0t: mean_value expected %0d, got %0d",
                              $time, oldest.mean, rsp_tdata);
               end
               if (rsp_tlast !== oldest.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("%0t: frame_last expected %0b, got %0b",
                              $time, oldest.last, rsp_tlast);
               end
            end
         end
      end
   end

   // Result side: random readiness, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_ack   <= 1'b0;
         hold_left  <= 0;
      end else if (hold_req != hold_ack) begin
         hold_ack   <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_pixel(input pixel_type px, input bit typed,
                             input pixel_type want_mean, input bit want_last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      beat_typed <= typed;
      beat_mean  <= want_mean;
      beat_last  <= want_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent_count++;
   endtask

   // Waits for the pipeline to empty before touching a register.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      reg_writes++;
      if (idx == CSR_LINE_LENGTH)
         eff_len = clamp_dim(32'(val[LEN_W-1:0]), TB_MAX_LINE);
      else
         eff_cnt = clamp_dim(32'(val[CNT_W-1:0]), TB_MAX_LINES);
   endtask

   function automatic pixel_type pick_pixel(input int mode, input pixel_type level);
      case (mode)
         6:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         7:       return pixel_type'($urandom_range(15));
         8:       return pixel_type'($urandom_range(16'hFFFF, 16'hFFF0));
         9:       return level;
         default: return pixel_type'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic send_run(input int beats, input int mode);
      pixel_type level;
      begin
         level = pixel_type'($urandom_range(16'hFFFF));
         for (int b = 0; b < beats; b++)
            send_pixel(pick_pixel(mode, level), 1'b0, '0, 1'b0);
      end
   endtask

   // A small frame geometry, whole frames and often a partial one, so that
   // the next register write tends to land in the middle of a frame.
   task automatic random_phase();
      int unsigned len_raw, cnt_raw, area, beats;
      int          which;
      begin
         len_raw = ($urandom_range(99) < 15) ? $urandom_range(4) :
                   ($urandom_range(99) < 10) ? $urandom_range(24, 13) : $urandom_range(12, 5);
         cnt_raw = ($urandom_range(99) < 15) ? $urandom_range(4) : $urandom_range(9, 5);
         which   = $urandom_range(2);
         if (which != 2)
            write_reg(CSR_LINE_LENGTH, CSR_W'(len_raw));
         if (which != 1)
            write_reg(CSR_LINE_COUNT, CSR_W'(cnt_raw));
         area = eff_len * eff_cnt;
         if ($urandom_range(99) < 15)
            beats = $urandom_range(area, 1);
         else begin
            beats = area * $urandom_range(3, 1);
            if ($urandom_range(99) < 40)
               beats += $urandom_range(area - 1, 1);
         end
         send_run(beats, $urandom_range(9));
      end
   endtask

   initial begin
      int target;

      // Rows: a line length write below range and a line count write of 6, then
      // a 5-wide, 6-line frame of full white whose last line turns black.
      plan[0] = '{1'b1, CSR_LINE_LENGTH, 13'd0, 0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0};
      plan[1] = '{1'b1, CSR_LINE_COUNT, 13'd6, 0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0};
      plan[2] = '{1'b0, CSR_LINE_LENGTH, 13'd0, 25, 16'hFFFF, 16'hFFFF, 1'b1, 16'd65535, 1'b0};
      plan[3] = '{1'b0, CSR_LINE_LENGTH, 13'd0, 5, 16'h0000, 16'h0000, 1'b1, 16'd52428, 1'b1};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 80;
      foreach (plan[i]) begin
         if (plan[i].reg_write)
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         else
            for (int b = 0; b < plan[i].beats; b++) begin
               if (b == plan[i].beats - 1)
                  send_pixel(plan[i].tail, plan[i].typed,
                             plan[i].want_mean, plan[i].want_last);
               else
                  send_pixel(plan[i].fill, 1'b0, '0, 1'b0);
            end
      end

      target = sent_count + 300;
      while (sent_count < target)
         random_phase();

      send_idle_pct = 80;
      recv_idle_pct = 25;
      target = sent_count + 300;
      while (sent_count < target)
         random_phase();

      send_idle_pct = 0;
      recv_idle_pct = 0;

      // Output held off while pixels keep coming, so the input has to stall.
      write_reg(CSR_LINE_LENGTH, 13'd6);
      write_reg(CSR_LINE_COUNT, 13'd8);
      hold_req <= ~hold_req;
      send_run(200, 0);

      // Largest geometries, each for the start of a frame; the all-ones write
      // is masked to the field width and then limited to the maximum.
      write_reg(CSR_LINE_LENGTH, 13'h1FFF);
      write_reg(CSR_LINE_COUNT, 13'd5);
      send_run(120, 0);
      write_reg(CSR_LINE_LENGTH, 13'd5);
      write_reg(CSR_LINE_COUNT, 13'h1FFF);
      send_run(120, 0);
      write_reg(CSR_LINE_LENGTH, 13'd1025);
      write_reg(CSR_LINE_COUNT, 13'd4097);
      send_run(40, 0);

      target = sent_count + 300;
      while (sent_count < target)
         random_phase();

      req_tvalid <= 1'b0;
      while (pending_means.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixels, checked %0d filtered beats over %0d frame ends,",
               sent_count, means_checked, frames_closed);
      $display("%0d geometry writes below, inside and above range, three stall mixes.",
               reg_writes);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
